@@ rtl/r3es_pkg.sv @@
// shared types and constants for the rgb 3x3 edge stencil
package r3es_pkg;

  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = CHANNELS * CH_W;
  localparam int unsigned FW_W       = 12;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned COL_W      = 12;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CNT_W      = 5;

  localparam logic [FW_W-1:0] FW_RESET   = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET   = 13'd480;
  localparam logic [FW_W-1:0] FW_MIN     = 12'd3;
  localparam logic [FH_W-1:0] FH_MIN     = 13'd3;
  localparam logic [FH_W-1:0] FH_MAX     = 13'd4096;
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(POS_W);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] in_ch0;
    logic [CH_W-1:0] in_ch1;
    logic [CH_W-1:0] in_ch2;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] out_ch0;
    logic [CH_W-1:0] out_ch1;
    logic [CH_W-1:0] out_ch2;
    logic            last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic             is_pix;
    logic             emit;
    logic             border;
    logic             last;
    logic [COL_W-1:0] col;
  } pos_info_t;

endpackage

@@ rtl/r3es_lane.sv @@
// one channel lane: eight neighbors minus seven times the center, modulo 256
module r3es_lane import r3es_pkg::*; (
  input  logic [8:0][CH_W-1:0] taps_i,
  output logic [CH_W-1:0]      res_o
);

  logic [CH_W-1:0] acc;
  logic [CH_W-1:0] ctr;

  always_comb begin
    acc = '0;
    ctr = taps_i[4];
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        acc = acc + taps_i[i];
      end
    end
    res_o = acc - {ctr[CH_W-4:0], 3'b000} + ctr;
  end

endmodule

@@ rtl/r3es_line.sv @@
// line store memory holding the two previous rows per column
module r3es_line import r3es_pkg::*; #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [2*PIX_W-1:0]   rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [2*PIX_W-1:0]   wr_data_i
);

  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ rtl/r3es_pos.sv @@
// frame geometry registers, input and output position counters, realignment divider
module r3es_pos import r3es_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic                  func_i,
  output logic                  busy_o,
  output pos_info_t             info_o
);

  logic [FW_W-1:0]  fw_q;
  logic [FH_W-1:0]  fh_q;
  logic [COL_W-1:0] w;
  logic [FH_W-1:0]  h;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [POS_W-1:0] q_q, q_d;
  logic [POS_W-1:0] p_q, p_d;
  logic [POS_W-1:0] pr_q, pr_d;
  logic [COL_W-1:0] pc_q, pc_d;
  logic [POS_W-1:0] n_q;
  logic [POS_W-1:0] mul_q;

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [POS_W-1:0] div_q;
  logic [COL_W:0]   rem_q;

  logic [POS_W:0]   n_prod;
  logic [POS_W-1:0] rw_prod;
  logic [POS_W:0]   lag_full;
  logic [POS_W-1:0] lag;
  logic [COL_W:0]   trial;
  logic             trial_ge;
  logic             emit;
  logic             border;
  logic             last;
  logic [POS_W:0]   q_jump;

  // clamped geometry
  always_comb begin
    if (fw_q < FW_MIN) begin
      w = FW_MIN;
    end else if (32'(fw_q) > MAX_WIDTH) begin
      w = COL_W'(MAX_WIDTH);
    end else begin
      w = fw_q;
    end
    if (fh_q < FH_MIN) begin
      h = FH_MIN;
    end else if (fh_q > FH_MAX) begin
      h = FH_MAX;
    end else begin
      h = fh_q;
    end
  end

  assign n_prod  = {13'b0, w} * {12'b0, h};
  assign rw_prod = {12'b0, row_q} * {12'b0, w};

  // restoring divider step
  assign trial    = {rem_q[COL_W-1:0], div_q[POS_W-1]};
  assign trial_ge = trial >= {1'b0, w};

  always_comb begin
    if (q_q >= p_q) begin
      lag_full = {1'b0, q_q} - {1'b0, p_q};
    end else begin
      lag_full = {1'b0, q_q} + {1'b0, n_q} - {1'b0, p_q};
    end
    lag    = lag_full[POS_W-1:0];
    emit   = func_i ? (lag != '0) : (lag > POS_W'(w));
    border = (pr_q == '0) || (pr_q >= POS_W'(h - 13'd1)) ||
             (pc_q == '0) || (pc_q == w - 12'd1);
    last   = p_q == n_q - 24'd1;
    q_jump = {1'b0, q_q} + (POS_W+1)'(w) - (POS_W+1)'(col_q);
  end

  // next positions for an accepted word
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    q_d   = q_q;
    p_d   = p_q;
    pr_d  = pr_q;
    pc_d  = pc_q;
    if (!func_i) begin
      if ({1'b0, col_q} + 13'd1 >= {1'b0, w}) begin
        col_d = '0;
        if ({1'b0, row_q} + 14'd1 >= {1'b0, h}) begin
          row_d = '0;
          q_d   = '0;
        end else begin
          row_d = row_q + 12'd1;
          q_d   = q_jump[POS_W-1:0];
        end
      end else begin
        col_d = col_q + 12'd1;
        q_d   = q_q + 24'd1;
      end
    end
    if (emit) begin
      if ({1'b0, p_q} + 25'd1 >= {1'b0, n_q}) begin
        p_d  = '0;
        pr_d = '0;
        pc_d = '0;
      end else begin
        p_d = p_q + 24'd1;
        if (pc_q == w - 12'd1) begin
          pc_d = '0;
          pr_d = pr_q + 24'd1;
        end else begin
          pc_d = pc_q + 12'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FW_RESET;
      fh_q   <= FH_RESET;
      col_q  <= '0;
      row_q  <= '0;
      q_q    <= '0;
      p_q    <= '0;
      pr_q   <= '0;
      pc_q   <= '0;
      n_q    <= '0;
      mul_q  <= '0;
      busy_q <= 1'b1;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH: begin
            fw_q <= cfg_data_i[FW_W-1:0];
          end
          CFG_FRAME_HEIGHT: begin
            fh_q <= cfg_data_i[FH_W-1:0];
          end
          default: begin
          end
        endcase
        busy_q <= 1'b1;
        cnt_q  <= '0;
        div_q  <= p_q;
        rem_q  <= '0;
      end else if (busy_q) begin
        n_q   <= n_prod[POS_W-1:0];
        mul_q <= rw_prod;
        q_q   <= mul_q + POS_W'(col_q);
        if (cnt_q == DIV_STEPS) begin
          pr_q   <= div_q;
          pc_q   <= rem_q[COL_W-1:0];
          busy_q <= 1'b0;
        end else begin
          rem_q <= trial_ge ? (trial - {1'b0, w}) : trial;
          div_q <= {div_q[POS_W-2:0], trial_ge};
          cnt_q <= cnt_q + 5'd1;
        end
      end else if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
        q_q   <= q_d;
        p_q   <= p_d;
        pr_q  <= pr_d;
        pc_q  <= pc_d;
      end
    end
  end

  assign busy_o = busy_q;

  always_comb begin
    info_o.is_pix = !func_i;
    info_o.emit   = emit;
    info_o.border = border;
    info_o.last   = last;
    info_o.col    = col_q;
  end

endmodule

@@ rtl/rgb_3x3_edge_stencil.sv @@
// 3x3 edge stencil over rgb raster pixels: line stores, window, lanes, merge
// a result word passes the stage one register and then the output register after its input word is accepted
// throughput: one word per cycle while not busy, no configuration write is pending and the output is not stalled
// reset clears window and counters, then realignment runs with input not ready
// every configuration write starts the same realignment of the output counters
module rgb_3x3_edge_stencil import r3es_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic      busy;
  logic      in_acc;
  logic      adv;
  logic      s1_adv;
  pos_info_t info;

  logic                    s1_valid_q;
  pos_info_t               s1_info_q;
  logic [PIX_W-1:0]        s1_pix_q;
  logic [2*PIX_W-1:0]      rd_data;
  logic [PIX_W-1:0]        rd_older;
  logic [PIX_W-1:0]        rd_newer;

  logic [2:0][2:0][PIX_W-1:0] win_q;
  logic [2:0][2:0][PIX_W-1:0] win_d;
  logic [CHANNELS-1:0][CH_W-1:0] lane_res;

  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t out_word_d;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && adv;
  assign in_ready_o  = !busy && !cfg_valid_i && (!s1_valid_q || adv);
  assign in_acc      = in_valid_i && in_ready_o;

  r3es_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_acc),
    .func_i     (in_word_i.func),
    .busy_o     (busy),
    .info_o     (info)
  );

  r3es_line #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc && !in_word_i.func),
    .rd_addr_i (AW'(info.col)),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv && s1_info_q.is_pix),
    .wr_addr_i (AW'(s1_info_q.col)),
    .wr_data_i ({rd_newer, s1_pix_q})
  );

  assign rd_older = rd_data[2*PIX_W-1:PIX_W];
  assign rd_newer = rd_data[PIX_W-1:0];

  // stage one: position decision and pending line store read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_info_q <= info;
      s1_pix_q  <= {in_word_i.in_ch2, in_word_i.in_ch1, in_word_i.in_ch0};
    end
  end

  // window shift, newest column on the right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = rd_older;
    win_d[1][2] = rd_newer;
    win_d[2][2] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv && s1_info_q.is_pix) begin
      win_q <= win_d;
    end
  end

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    logic [8:0][CH_W-1:0] taps;

    always_comb begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          taps[r*3+k] = win_d[r][k][ch*CH_W +: CH_W];
        end
      end
    end

    r3es_lane u_lane (
      .taps_i (taps),
      .res_o  (lane_res[ch])
    );
  end

  // merge lanes into the output word
  always_comb begin
    if (!s1_info_q.is_pix || s1_info_q.border) begin
      out_word_d.out_ch0 = '0;
      out_word_d.out_ch1 = '0;
      out_word_d.out_ch2 = '0;
    end else begin
      out_word_d.out_ch0 = lane_res[0];
      out_word_d.out_ch1 = lane_res[1];
      out_word_d.out_ch2 = lane_res[2];
    end
    out_word_d.last_of_frame = s1_info_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && s1_info_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_info_q.emit) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
